/* design/crcdf_pkg.sv */
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, codes and CRC step functions for the frame deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] HEADER_EXTRA = 16'd6;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ABORTED  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_START_FIRST  = 2'd0;
   localparam logic [1:0] CSR_START_SECOND = 2'd1;
   localparam logic [1:0] CSR_END_FIRST    = 2'd2;
   localparam logic [1:0] CSR_END_SECOND   = 2'd3;

   typedef struct packed {
      logic [7:0] start_first;
      logic [7:0] start_second;
      logic [7:0] end_first;
      logic [7:0] end_second;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  source_addr;
      logic [7:0]  dest_addr;
      logic [7:0]  command_kind;
      logic [7:0]  command_group;
      logic [15:0] command_word;
      logic [15:0] reserved_word;
      logic [15:0] payload_length;
      logic        payload_crc_ok;
   } rec_type;

   // crc-8, reflected, poly 0x31
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      end
      return c;
   endfunction

   // crc-16/xmodem, poly 0x1021
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* design/crcdf_parser.sv */
// ----------------------------------------------------------------------------
// crcdf_parser
// Front end: walks the frame byte by byte, checks both CRCs and the codes,
// and pushes one result record for each payload byte and frame end.
// ----------------------------------------------------------------------------
module crcdf_parser import crcdf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_take,
   input  logic [7:0] in_byte,
   input  cfg_type    cfg,
   output logic       push,
   output rec_type    rec
);

   typedef enum logic [4:0] {
      PH_HUNT, PH_START2, PH_SRC, PH_DST, PH_LEN_LO, PH_LEN_HI, PH_HCRC,
      PH_KIND, PH_GROUP, PH_CMD_LO, PH_CMD_HI, PH_RES_LO, PH_RES_HI,
      PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI, PH_TAIL1, PH_TAIL2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  hcrc_ff, hcrc_in;
   logic [15:0] bcrc_ff, bcrc_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  dst_ff, dst_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  group_ff, group_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [15:0] res_ff, res_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic        match_ff, match_in;
   logic        emit;
   logic [1:0]  emit_kind;
   logic [7:0]  emit_byte;

   always_comb begin
      phase_in  = phase_ff;
      hcrc_in   = hcrc_ff;
      bcrc_in   = bcrc_ff;
      left_in   = left_ff;
      len_in    = len_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      kind_in   = kind_ff;
      group_in  = group_ff;
      cmd_in    = cmd_ff;
      res_in    = res_ff;
      crc_lo_in = crc_lo_ff;
      match_in  = match_ff;
      emit      = 1'b0;
      emit_kind = KIND_PAYLOAD;
      emit_byte = 8'h00;
      if (in_take) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_byte == cfg.start_first) begin
                  hcrc_in  = crc8_step(8'h00, in_byte);
                  phase_in = PH_START2;
               end
            end
            PH_START2: begin
               if (in_byte == cfg.start_second) begin
                  hcrc_in  = crc8_step(hcrc_ff, in_byte);
                  phase_in = PH_SRC;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SRC: begin
               src_in   = in_byte;
               hcrc_in  = crc8_step(hcrc_ff, in_byte);
               phase_in = PH_DST;
            end
            PH_DST: begin
               dst_in   = in_byte;
               hcrc_in  = crc8_step(hcrc_ff, in_byte);
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in   = {8'h00, in_byte};
               hcrc_in  = crc8_step(hcrc_ff, in_byte);
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in   = {in_byte, len_ff[7:0]};
               hcrc_in  = crc8_step(hcrc_ff, in_byte);
               phase_in = ({in_byte, len_ff[7:0]} < HEADER_EXTRA) ? PH_HUNT : PH_HCRC;
            end
            PH_HCRC: begin
               phase_in = (in_byte == hcrc_ff) ? PH_KIND : PH_HUNT;
            end
            PH_KIND: begin
               kind_in  = in_byte;
               bcrc_in  = crc16_step(16'h0000, in_byte);
               phase_in = PH_GROUP;
            end
            PH_GROUP: begin
               group_in = in_byte;
               bcrc_in  = crc16_step(bcrc_ff, in_byte);
               phase_in = PH_CMD_LO;
            end
            PH_CMD_LO: begin
               cmd_in   = {8'h00, in_byte};
               bcrc_in  = crc16_step(bcrc_ff, in_byte);
               phase_in = PH_CMD_HI;
            end
            PH_CMD_HI: begin
               cmd_in   = {in_byte, cmd_ff[7:0]};
               bcrc_in  = crc16_step(bcrc_ff, in_byte);
               phase_in = PH_RES_LO;
            end
            PH_RES_LO: begin
               res_in   = {8'h00, in_byte};
               bcrc_in  = crc16_step(bcrc_ff, in_byte);
               phase_in = PH_RES_HI;
            end
            PH_RES_HI: begin
               res_in   = {in_byte, res_ff[7:0]};
               bcrc_in  = crc16_step(bcrc_ff, in_byte);
               left_in  = len_ff - HEADER_EXTRA;
               phase_in = (len_ff == HEADER_EXTRA) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               bcrc_in   = crc16_step(bcrc_ff, in_byte);
               left_in   = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  phase_in = PH_CRC_LO;
               end
               emit      = 1'b1;
               emit_byte = in_byte;
            end
            PH_CRC_LO: begin
               crc_lo_in = in_byte;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               match_in = (crc_lo_ff == bcrc_ff[7:0]) && (in_byte == bcrc_ff[15:8]);
               phase_in = PH_TAIL1;
            end
            PH_TAIL1: begin
               if (in_byte != cfg.end_first) begin
                  phase_in  = PH_HUNT;
                  emit      = 1'b1;
                  emit_kind = KIND_ABORTED;
               end else begin
                  phase_in = PH_TAIL2;
               end
            end
            PH_TAIL2: begin
               phase_in  = PH_HUNT;
               emit      = 1'b1;
               emit_kind = (in_byte == cfg.end_second) ? KIND_COMPLETE : KIND_ABORTED;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   assign push                = emit;
   assign rec.item_kind       = emit_kind;
   assign rec.payload_byte    = emit_byte;
   assign rec.source_addr     = src_ff;
   assign rec.dest_addr       = dst_ff;
   assign rec.command_kind    = kind_ff;
   assign rec.command_group   = group_ff;
   assign rec.command_word    = cmd_ff;
   assign rec.reserved_word   = res_ff;
   assign rec.payload_length  = len_ff - HEADER_EXTRA;
   assign rec.payload_crc_ok  = (emit_kind == KIND_PAYLOAD) ? 1'b0 : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         hcrc_ff   <= '0;
         bcrc_ff   <= '0;
         left_ff   <= '0;
         len_ff    <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         kind_ff   <= '0;
         group_ff  <= '0;
         cmd_ff    <= '0;
         res_ff    <= '0;
         crc_lo_ff <= '0;
         match_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hcrc_ff   <= hcrc_in;
         bcrc_ff   <= bcrc_in;
         left_ff   <= left_in;
         len_ff    <= len_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         kind_ff   <= kind_in;
         group_ff  <= group_in;
         cmd_ff    <= cmd_in;
         res_ff    <= res_in;
         crc_lo_ff <= crc_lo_in;
         match_ff  <= match_in;
      end
   end

   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      push |-> (phase_ff == PH_PAYLOAD || phase_ff == PH_TAIL1 || phase_ff == PH_TAIL2))
      else $error("result pushed outside payload or tail phase");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != 16'd0)
      else $error("payload phase with no bytes left");

   a_payload_flag: assert property (@(posedge clock) disable iff (reset)
      (push && rec.item_kind == KIND_PAYLOAD) |-> !rec.payload_crc_ok)
      else $error("crc flag set on payload beat");

endmodule

/* design/crcdf_queue.sv */
// ----------------------------------------------------------------------------
// crcdf_queue
// Back end: small result queue between the parser and the result channel;
// its head entry is the registered output.
// ----------------------------------------------------------------------------
module crcdf_queue import crcdf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   output logic    out_valid,
   input  logic    out_ready,
   output rec_type out_rec
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_rec   = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? PTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not follow push");

endmodule

/* design/crc_frame_deframer.sv */
// ----------------------------------------------------------------------------
// crc_frame_deframer
// Frame parser with crc-8 header check and crc-16 body check.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle on the req channel whenever the result
// queue has room; each byte is parsed in the cycle it is accepted and any
// result it causes (payload byte or frame end) goes into the result queue,
// whose head drives rsp. A four-entry result queue lets the sink stall
// without stopping the byte stream until the queue is full, at which point
// req_ready drops until a rsp beat is taken. The user must write the code
// registers through the csr port only while no frame is in flight; the block itself does not enforce this.
module crc_frame_deframer import crcdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_source_addr,
   output logic [7:0]  rsp_dest_addr,
   output logic [7:0]  rsp_command_kind,
   output logic [7:0]  rsp_command_group,
   output logic [15:0] rsp_command_word,
   output logic [15:0] rsp_reserved_word,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_payload_crc_ok,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    take;
   logic    push;
   logic    full;
   rec_type push_rec;
   rec_type head_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_FIRST:  cfg_ff.start_first  <= csr_wdata;
            CSR_START_SECOND: cfg_ff.start_second <= csr_wdata;
            CSR_END_FIRST:    cfg_ff.end_first    <= csr_wdata;
            CSR_END_SECOND:   cfg_ff.end_second   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   crcdf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_take (take),
      .in_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .push    (push),
      .rec     (push_rec)
   );

   crcdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rec   (head_rec)
   );

   assign rsp_item_kind      = head_rec.item_kind;
   assign rsp_payload_byte   = head_rec.payload_byte;
   assign rsp_source_addr    = head_rec.source_addr;
   assign rsp_dest_addr      = head_rec.dest_addr;
   assign rsp_command_kind   = head_rec.command_kind;
   assign rsp_command_group  = head_rec.command_group;
   assign rsp_command_word   = head_rec.command_word;
   assign rsp_reserved_word  = head_rec.reserved_word;
   assign rsp_payload_length = head_rec.payload_length;
   assign rsp_payload_crc_ok = head_rec.payload_crc_ok;

endmodule

/* tb/crc_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// crc_frame_deframer_tb
// Self-checking bench for the frame deframer. Bytes go in one per beat, with
// a short scripted opening, then random frames (mostly well formed, the rest
// noise or frames broken in one place) under several sets of start and tail
// codes. An in-bench parser predicts every payload and end-of-frame beat,
// and each rsp beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module crc_frame_deframer_tb import crcdf_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 400000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 120;
   localparam int PHASE_COUNT     = 5;
   localparam int PHASE_BYTES     = 80;
   localparam int SCRIPT_ROWS     = 33;

   // parser position, one per byte of the frame layout
   typedef enum logic [4:0] {
      SEEK_SYNC1, SEEK_SYNC2, GET_SRC, GET_DST, GET_LEN_LO, GET_LEN_HI, GET_HCRC,
      GET_KIND, GET_GROUP, GET_CMD_LO, GET_CMD_HI, GET_RSV_LO, GET_RSV_HI,
      GET_DATA, GET_FCS_LO, GET_FCS_HI, GET_TAIL1, GET_TAIL2
   } parse_pos_type;

   typedef enum logic [2:0] {
      FAULT_NONE, FAULT_NOISE, FAULT_SYNC2, FAULT_SHORT_LEN, FAULT_HCRC,
      FAULT_FCS, FAULT_TAIL1, FAULT_TAIL2
   } fault_type;

   typedef enum logic [2:0] {
      ROW_RAW, ROW_SYNC, ROW_HEAD, ROW_HCRC, ROW_BODY, ROW_FCS_LO, ROW_FCS_HI
   } row_op_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_TOGGLE, SINK_COIN, SINK_SPARSE} sink_mode_type;

   // crc rows carry an xor mask in value; pinned rows carry a typed end beat
   typedef struct packed {
      row_op_type  op;
      logic [7:0]  value;
      logic        pinned;
      logic [1:0]  pin_kind;
      logic        pin_ok;
      logic [15:0] pin_len;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_source_addr;
   logic [7:0]  rsp_dest_addr;
   logic [7:0]  rsp_command_kind;
   logic [7:0]  rsp_command_group;
   logic [15:0] rsp_command_word;
   logic [15:0] rsp_reserved_word;
   logic [15:0] rsp_payload_length;
   logic        rsp_payload_crc_ok;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_wdata = 8'h00;

   crc_frame_deframer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_source_addr    (rsp_source_addr),
      .rsp_dest_addr      (rsp_dest_addr),
      .rsp_command_kind   (rsp_command_kind),
      .rsp_command_group  (rsp_command_group),
      .rsp_command_word   (rsp_command_word),
      .rsp_reserved_word  (rsp_reserved_word),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_crc_ok (rsp_payload_crc_ok),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // bench copy of the parser state and the code registers
   cfg_type       codes = '0;
   parse_pos_type parse_at = SEEK_SYNC1;
   logic [7:0]    hdr_crc = 8'h00;
   logic [15:0]   body_crc = 16'h0000;
   logic [15:0]   left_q = 16'h0000;
   logic [15:0]   len_q = 16'h0000;
   logic [7:0]    src_q = 8'h00;
   logic [7:0]    dst_q = 8'h00;
   logic [7:0]    kind_q = 8'h00;
   logic [7:0]    group_q = 8'h00;
   logic [15:0]   cmd_q = 16'h0000;
   logic [15:0]   rsv_q = 16'h0000;
   logic [7:0]    fcs_lo_q = 8'h00;
   logic          fcs_ok_q = 1'b0;

   rec_type     awaited_items[$];
   logic [7:0]  frame_bytes[$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          burst_left = 0;
   int          cycle_count = 0;
   bit          hold_request = 1'b0;

   script_row_type script_rows [SCRIPT_ROWS] = '{
      '{ROW_RAW,    8'h55, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // dropped while hunting
      '{ROW_RAW,    8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_RAW,    8'h7F, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // wrong second start
      '{ROW_SYNC,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // length zero, too short
      '{ROW_SYNC,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // largest length
      '{ROW_HCRC,   8'h01, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // corrupt header crc
      '{ROW_RAW,    8'h7F, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // back to hunting either way
      '{ROW_SYNC,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h06, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_HEAD,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // empty payload
      '{ROW_HCRC,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_BODY,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_BODY,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_BODY,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_BODY,   8'hFF, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_BODY,   8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_BODY,   8'h80, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_FCS_LO, 8'h00, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},
      '{ROW_FCS_HI, 8'h01, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0},  // body crc off by one bit
      '{ROW_RAW,    8'hA5, 1'b1, KIND_ABORTED, 1'b0, 16'd0}   // bad first tail
   };

   // reflected crc-8, fed one bit at a time from the lsb
   function automatic logic [7:0] hdr_crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c = c >> 1;
         if (fb) c = c ^ 8'h8C;
      end
      return c;
   endfunction

   // crc-16 poly 0x1021, fed one bit at a time from the msb
   function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = c << 1;
         if (fb) c = c ^ 16'h1021;
      end
      return c;
   endfunction

   // advances the bench parser by one byte; returns 1 when a beat is due
   function automatic bit deframe_byte(input logic [7:0] b, output rec_type r);
      bit         emitted;
      logic [1:0] kind;
      logic [7:0] data;
      emitted = 1'b0;
      kind = KIND_PAYLOAD;
      data = 8'h00;
      case (parse_at)
         SEEK_SYNC1: if (b == codes.start_first) begin
            hdr_crc = hdr_crc8_next(8'h00, b);
            parse_at = SEEK_SYNC2;
         end
         SEEK_SYNC2: if (b == codes.start_second) begin
            hdr_crc = hdr_crc8_next(hdr_crc, b);
            parse_at = GET_SRC;
         end else begin
            parse_at = SEEK_SYNC1;
         end
         GET_SRC: begin
            src_q = b;
            hdr_crc = hdr_crc8_next(hdr_crc, b);
            parse_at = GET_DST;
         end
         GET_DST: begin
            dst_q = b;
            hdr_crc = hdr_crc8_next(hdr_crc, b);
            parse_at = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            len_q = {8'h00, b};
            hdr_crc = hdr_crc8_next(hdr_crc, b);
            parse_at = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            len_q[15:8] = b;
            hdr_crc = hdr_crc8_next(hdr_crc, b);
            parse_at = (len_q < HEADER_EXTRA) ? SEEK_SYNC1 : GET_HCRC;
         end
         GET_HCRC: parse_at = (b == hdr_crc) ? GET_KIND : SEEK_SYNC1;
         GET_KIND: begin
            kind_q = b;
            body_crc = crc16_xmodem(16'h0000, b);
            parse_at = GET_GROUP;
         end
         GET_GROUP: begin
            group_q = b;
            body_crc = crc16_xmodem(body_crc, b);
            parse_at = GET_CMD_LO;
         end
         GET_CMD_LO: begin
            cmd_q = {8'h00, b};
            body_crc = crc16_xmodem(body_crc, b);
            parse_at = GET_CMD_HI;
         end
         GET_CMD_HI: begin
            cmd_q[15:8] = b;
            body_crc = crc16_xmodem(body_crc, b);
            parse_at = GET_RSV_LO;
         end
         GET_RSV_LO: begin
            rsv_q = {8'h00, b};
            body_crc = crc16_xmodem(body_crc, b);
            parse_at = GET_RSV_HI;
         end
         GET_RSV_HI: begin
            rsv_q[15:8] = b;
            body_crc = crc16_xmodem(body_crc, b);
            left_q = len_q - HEADER_EXTRA;
            parse_at = (left_q == 16'd0) ? GET_FCS_LO : GET_DATA;
         end
         GET_DATA: begin
            body_crc = crc16_xmodem(body_crc, b);
            left_q = left_q - 16'd1;
            if (left_q == 16'd0) parse_at = GET_FCS_LO;
            emitted = 1'b1;
            data = b;
         end
         GET_FCS_LO: begin
            fcs_lo_q = b;
            parse_at = GET_FCS_HI;
         end
         GET_FCS_HI: begin
            fcs_ok_q = (fcs_lo_q == body_crc[7:0]) && (b == body_crc[15:8]);
            parse_at = GET_TAIL1;
         end
         GET_TAIL1: if (b != codes.end_first) begin
            parse_at = SEEK_SYNC1;
            emitted = 1'b1;
            kind = KIND_ABORTED;
         end else begin
            parse_at = GET_TAIL2;
         end
         GET_TAIL2: begin
            parse_at = SEEK_SYNC1;
            emitted = 1'b1;
            kind = (b == codes.end_second) ? KIND_COMPLETE : KIND_ABORTED;
         end
         default: parse_at = SEEK_SYNC1;
      endcase
      r.item_kind = kind;
      r.payload_byte = data;
      r.source_addr = src_q;
      r.dest_addr = dst_q;
      r.command_kind = kind_q;
      r.command_group = group_q;
      r.command_word = cmd_q;
      r.reserved_word = rsv_q;
      r.payload_length = len_q - HEADER_EXTRA;
      r.payload_crc_ok = (kind == KIND_PAYLOAD) ? 1'b0 : fcs_ok_q;
      return emitted;
   endfunction

   // one req beat, sent in bursts with random gaps between them
   task automatic send_byte(input logic [7:0] b, input logic pinned, input logic [1:0] pin_kind,
                            input logic pin_ok, input logic [15:0] pin_len);
      rec_type r;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (deframe_byte(b, r) || pinned) begin
         if (pinned) begin
            r.item_kind = pin_kind;
            r.payload_byte = 8'h00;
            r.payload_crc_ok = pin_ok;
            r.payload_length = pin_len;
         end
         awaited_items.push_back(r);
      end
      burst_left--;
      bytes_sent++;
   endtask

   // sender stops and waits for every awaited beat, then for the pipe to empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (awaited_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_code(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_START_FIRST:  codes.start_first = val;
         CSR_START_SECOND: codes.start_second = val;
         CSR_END_FIRST:    codes.end_first = val;
         default:          codes.end_second = val;
      endcase
   endtask

   // fills frame_bytes with one frame, broken in the way the fault names
   task automatic build_frame(input fault_type fault, input int plen);
      logic [7:0]  b;
      logic [7:0]  hcrc;
      logic [15:0] bcrc;
      logic [15:0] len;
      logic [7:0]  head [6];
      frame_bytes.delete();
      if (fault == FAULT_NOISE) begin
         repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == codes.start_first) b = ~b;
            frame_bytes.push_back(b);
         end
         return;
      end
      if (fault == FAULT_SYNC2) begin
         b = 8'($urandom_range(0, 255));
         if (b == codes.start_second) b = ~b;
         frame_bytes.push_back(codes.start_first);
         frame_bytes.push_back(b);
         return;
      end
      if (fault == FAULT_SHORT_LEN) len = 16'($urandom_range(0, 5));
      else if (fault == FAULT_HCRC && $urandom_range(0, 1) == 1)
         len = 16'($urandom_range(6, 65535));
      else len = 16'(plen) + HEADER_EXTRA;
      head = '{codes.start_first, codes.start_second, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), len[7:0], len[15:8]};
      hcrc = 8'h00;
      foreach (head[i]) begin
         hcrc = hdr_crc8_next(hcrc, head[i]);
         frame_bytes.push_back(head[i]);
      end
      if (fault == FAULT_SHORT_LEN) return;
      if (fault == FAULT_HCRC) begin
         // keep the stray byte from restarting a frame
         do b = hcrc ^ 8'($urandom_range(1, 255)); while (b == codes.start_first);
         frame_bytes.push_back(b);
         return;
      end
      frame_bytes.push_back(hcrc);
      bcrc = 16'h0000;
      for (int i = 0; i < 6 + plen; i++) begin
         b = 8'($urandom_range(0, 255));
         bcrc = crc16_xmodem(bcrc, b);
         frame_bytes.push_back(b);
      end
      if (fault == FAULT_FCS) bcrc = bcrc ^ 16'($urandom_range(1, 65535));
      frame_bytes.push_back(bcrc[7:0]);
      frame_bytes.push_back(bcrc[15:8]);
      if (fault == FAULT_TAIL1) begin
         do b = 8'($urandom_range(0, 255)); while (b == codes.end_first);
         frame_bytes.push_back(b);
         return;
      end
      frame_bytes.push_back(codes.end_first);
      if (fault == FAULT_TAIL2) begin
         do b = 8'($urandom_range(0, 255)); while (b == codes.end_second);
         frame_bytes.push_back(b);
      end else begin
         frame_bytes.push_back(codes.end_second);
      end
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, KIND_PAYLOAD, 1'b0, 16'd0);
   endtask

   function automatic fault_type pick_fault();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return FAULT_NONE;
      if (roll < 66) return FAULT_NOISE;
      if (roll < 71) return FAULT_SYNC2;
      if (roll < 76) return FAULT_SHORT_LEN;
      if (roll < 82) return FAULT_HCRC;
      if (roll < 88) return FAULT_FCS;
      if (roll < 94) return FAULT_TAIL1;
      return FAULT_TAIL2;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < WATCHDOG_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // sink pacing; a hold request holds ready low for a long stretch
   initial begin
      sink_mode_type mode;
      int            span;
      forever begin
         mode = sink_mode_type'($urandom_range(0, 3));
         span = $urandom_range(8, 48);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            if (hold_request) begin
               rsp_ready <= 1'b0;
               for (int held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
               hold_request = 1'b0;
            end else begin
               case (mode)
                  SINK_OPEN:   rsp_ready <= 1'b1;
                  SINK_TOGGLE: rsp_ready <= k[0];
                  SINK_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                  default:     rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_items.size() == 0) begin
            $error("rsp beat with nothing awaited: kind 0x%0h byte 0x%0h",
                   rsp_item_kind, rsp_payload_byte);
            fail_count++;
         end else begin
            want = awaited_items.pop_front();
            check_field("item_kind", 16'(want.item_kind), 16'(rsp_item_kind));
            check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_payload_byte));
            check_field("source_addr", 16'(want.source_addr), 16'(rsp_source_addr));
            check_field("dest_addr", 16'(want.dest_addr), 16'(rsp_dest_addr));
            check_field("command_kind", 16'(want.command_kind), 16'(rsp_command_kind));
            check_field("command_group", 16'(want.command_group), 16'(rsp_command_group));
            check_field("command_word", want.command_word, rsp_command_word);
            check_field("reserved_word", want.reserved_word, rsp_reserved_word);
            check_field("payload_length", want.payload_length, rsp_payload_length);
            check_field("payload_crc_ok", 16'(want.payload_crc_ok), 16'(rsp_payload_crc_ok));
         end
      end
   end

   initial begin
      logic [7:0]  b;
      logic [7:0]  run_hcrc;
      logic [15:0] run_bcrc;
      cfg_type     setting;
      int          phase_start;
      int          plen;
      run_hcrc = 8'h00;
      run_bcrc = 16'h0000;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scripted opening with the codes still at their reset value
      foreach (script_rows[i]) begin
         case (script_rows[i].op)
            ROW_SYNC: begin
               b = script_rows[i].value;
               run_hcrc = hdr_crc8_next(8'h00, b);
            end
            ROW_HEAD: begin
               b = script_rows[i].value;
               run_hcrc = hdr_crc8_next(run_hcrc, b);
            end
            ROW_HCRC: begin
               b = run_hcrc ^ script_rows[i].value;
               run_bcrc = 16'h0000;
            end
            ROW_BODY: begin
               b = script_rows[i].value;
               run_bcrc = crc16_xmodem(run_bcrc, b);
            end
            ROW_FCS_LO: b = run_bcrc[7:0] ^ script_rows[i].value;
            ROW_FCS_HI: b = run_bcrc[15:8] ^ script_rows[i].value;
            default:    b = script_rows[i].value;
         endcase
         send_byte(b, script_rows[i].pinned, script_rows[i].pin_kind,
                   script_rows[i].pin_ok, script_rows[i].pin_len);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         case (p)
            0:       setting = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
            2:       setting = '{8'h00, 8'hFF, 8'hFF, 8'h00};
            4:       setting = '{8'h00, 8'h00, 8'h00, 8'h00};
            default: setting = 32'($urandom);
         endcase
         write_code(CSR_START_FIRST, setting.start_first);
         write_code(CSR_START_SECOND, setting.start_second);
         write_code(CSR_END_FIRST, setting.end_first);
         write_code(CSR_END_SECOND, setting.end_second);
         phase_start = bytes_sent;
         if (p == 1) begin
            // long sink stall against a long payload so the result queue backs up
            hold_request = 1'b1;
            build_frame(FAULT_NONE, 40);
            send_frame();
         end
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
            build_frame(pick_fault(), plen);
            send_frame();
            if ($urandom_range(0, 11) == 0) settle();
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
design/crcdf_pkg.sv
design/crcdf_parser.sv
design/crcdf_queue.sv
design/crc_frame_deframer.sv
tb/crc_frame_deframer_tb.sv
